// File: src/first_fit_segment_allocator_defines.svh
// assertion macros shared by the checker
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define FFSA_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("allocator port check failed");

// next-cycle implication, sampled on clock, off during reset
`define FFSA_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("allocator port check failed");

`endif

// File: src/ffsa_pkg.sv
package ffsa_pkg;

   // fixed field widths of the request and response transactions
   localparam int SIZE_W   = 20;
   localparam int ADDR_W   = 19;
   localparam int STATUS_W = 2;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_APPEND
   } state_type;

endpackage

// File: src/first_fit_segment_allocator.sv
// first-fit contiguous allocator over a segment table held in one synchronous
// ram (one write and one registered read a cycle). a request is taken when start
// is high and busy is low. an allocate scans the live entries in table order, one
// per cycle through the ram read port, for the first free segment strictly longer
// than req_size; on success that segment is shrunk from the front and a busy
// segment is appended, by two writes in turn on the single write port. a
// free clears the busy bit of the first live entry whose start equals req_address.
// the next request can be taken once the scan ends (for a successful allocate,
// which scans at most NUM_SEGMENTS-1 entries, once both writes are done).
// the response sits
// on rsp_status/rsp_start_res for exactly one cycle with rsp_valid high and cannot
// be held off; it shows in the first cycle busy is low again, so a new transaction
// may start in that same cycle. after reset an init pass writes entry 0
// (busy is high meanwhile). free neighbors are never merged.
module first_fit_segment_allocator #(
   parameter int DISK_SIZE    = 524288,
   parameter int NUM_SEGMENTS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [ffsa_pkg::SIZE_W-1:0]   req_size,
   input  logic [ffsa_pkg::ADDR_W-1:0]   req_address,
   output logic                          rsp_valid,
   output logic [ffsa_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffsa_pkg::ADDR_W-1:0]   rsp_start_res
);

   localparam int SW      = ffsa_pkg::SIZE_W;
   localparam int AW      = ffsa_pkg::ADDR_W;
   // a segment start is always below DISK_SIZE, a length at most DISK_SIZE
   localparam int BASE_W  = $clog2(DISK_SIZE);
   localparam int LEN_W   = $clog2(DISK_SIZE + 1);
   localparam int IDX_W   = $clog2(NUM_SEGMENTS);
   localparam int CNT_W   = $clog2(NUM_SEGMENTS + 1);
   // common widths for the fit compare and the start match
   localparam int CMP_W   = (LEN_W > SW) ? LEN_W : SW;
   localparam int MATCH_W = (BASE_W > AW) ? BASE_W : AW;
   localparam int SUM_W   = ((BASE_W > SW) ? BASE_W : SW) + 1;

   typedef struct packed {
      logic              busy;
      logic [LEN_W-1:0]  len;
      logic [BASE_W-1:0] base;
   } entry_type;

   // segment table
   entry_type mem [NUM_SEGMENTS];

   ffsa_pkg::state_type  state_ff, state_in;
   logic                 kind_ff, kind_in;
   logic [SW-1:0]        size_ff, size_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   entry_type            hit_ff, hit_in;
   entry_type            rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [AW-1:0]        rsp_start_ff, rsp_start_in;

   // ram port controls
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   entry_type            mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;

   // scan evaluation on the entry read last cycle
   logic                 fit;
   logic                 match;
   logic                 hit;
   logic                 last;
   logic [SUM_W-1:0]     new_base;
   logic [CMP_W-1:0]     new_len;

   assign fit = !rd_data_ff.busy && (CMP_W'(rd_data_ff.len) > CMP_W'(size_ff));
   assign match = MATCH_W'(rd_data_ff.base) == MATCH_W'(addr_ff);
   assign hit = (kind_ff == ffsa_pkg::REQ_ALLOC) ? fit : match;
   assign last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // front shrink of the found free segment; cannot overflow since len > size
   assign new_base = SUM_W'(hit_ff.base) + SUM_W'(size_ff);
   assign new_len = CMP_W'(hit_ff.len) - CMP_W'(size_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   // table ram, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ffsa_pkg::STATUS_OK;
      rsp_start_in  = '0;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rd_data_ff;
      mem_raddr     = idx_ff;
      busy          = 1'b1;

      unique case (state_ff)
         ffsa_pkg::ST_INIT: begin
            // one free segment over the whole disk
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata.busy = 1'b0;
            mem_wdata.len  = LEN_W'(DISK_SIZE);
            mem_wdata.base = '0;
            count_in       = CNT_W'(1);
            state_in       = ffsa_pkg::ST_IDLE;
         end
         ffsa_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               kind_in   = req_type;
               size_in   = req_size;
               addr_in   = req_address;
               idx_in    = '0;
               mem_raddr = '0;
               state_in  = ffsa_pkg::ST_SCAN;
            end
         end
         ffsa_pkg::ST_SCAN: begin
            priority if (hit) begin
               if (kind_ff == ffsa_pkg::REQ_FREE) begin
                  // clear busy in place
                  mem_we         = 1'b1;
                  mem_wdata.busy = 1'b0;
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ffsa_pkg::STATUS_OK;
                  state_in       = ffsa_pkg::ST_IDLE;
               end else if (count_ff == CNT_W'(NUM_SEGMENTS)) begin
                  // fit exists but no room to append
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffsa_pkg::STATUS_FULL;
                  state_in      = ffsa_pkg::ST_IDLE;
               end else begin
                  hit_in   = rd_data_ff;
                  state_in = ffsa_pkg::ST_UPDATE;
               end
            end else if (last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (kind_ff == ffsa_pkg::REQ_ALLOC) ?
                               ffsa_pkg::STATUS_NO_SPACE : ffsa_pkg::STATUS_NOT_FOUND;
               state_in      = ffsa_pkg::ST_IDLE;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               mem_raddr = idx_ff + IDX_W'(1);
            end
         end
         ffsa_pkg::ST_UPDATE: begin
            // shrink the found segment from the front
            mem_we         = 1'b1;
            mem_waddr      = idx_ff;
            mem_wdata.busy = 1'b0;
            mem_wdata.len  = LEN_W'(new_len);
            mem_wdata.base = BASE_W'(new_base);
            state_in       = ffsa_pkg::ST_APPEND;
         end
         ffsa_pkg::ST_APPEND: begin
            // append the used segment at the end of the table
            mem_we         = 1'b1;
            mem_waddr      = count_ff[IDX_W-1:0];
            mem_wdata.busy = 1'b1;
            mem_wdata.len  = LEN_W'(size_ff);
            mem_wdata.base = hit_ff.base;
            count_in       = count_ff + CNT_W'(1);
            rsp_valid_in   = 1'b1;
            rsp_status_in  = ffsa_pkg::STATUS_OK;
            rsp_start_in   = AW'(hit_ff.base);
            state_in       = ffsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = ffsa_pkg::ST_INIT;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_start_res = rsp_start_ff;

endmodule

// File: src/ffsa_checker.sv
`include "first_fit_segment_allocator_defines.svh"

module ffsa_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted transaction always makes the block busy
   `FFSA_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)

   // a response only follows a busy cycle
   `FFSA_ASSERT_NOW(a_rsp_after_busy, rsp_valid, $past(busy))

   // every transaction passes through the scan state, so responses never come back to back
   `FFSA_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)

   // the response cycle is an idle cycle
   `FFSA_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);

// File: tb/first_fit_segment_allocator_test.sv
// directed and random checks of the first-fit segment allocator against an
// in-bench table model; one response is expected per accepted request
module first_fit_segment_allocator_test;
   import ffsa_pkg::*;

   localparam int DISK_UNITS   = 524288;
   localparam int TABLE_DEPTH  = 32;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 330;   // per idling phase
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;

   // one response transaction as the block reports it
   typedef struct packed {
      status_type             status;
      logic [ADDR_W-1:0]      start_res;
   } reply_t;

   // one row of the directed table; known rows carry a typed-in reply
   typedef struct packed {
      logic                   kind;
      logic [SIZE_W-1:0]      len;
      logic [ADDR_W-1:0]      address;
      logic                   known;
      reply_t                 want;
   } stim_row_t;

   // block inputs, all at known values from time zero
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                req_type    = REQ_ALLOC;
   logic [SIZE_W-1:0]   req_size    = '0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_start_res;

   // shadow copy of the segment table
   logic [ADDR_W-1:0]   tbl_base [TABLE_DEPTH];
   logic [SIZE_W-1:0]   tbl_len  [TABLE_DEPTH];
   logic                tbl_used [TABLE_DEPTH];
   int                  tbl_live;

   reply_t              replies_due[$];
   stim_row_t           directed_rows[$];
   int                  send_idle_pct = 18;
   int                  fail_count    = 0;
   int                  cycle_count   = 0;
   int                  status_seen[4] = '{0, 0, 0, 0};

   first_fit_segment_allocator #(
      .DISK_SIZE    (DISK_UNITS),
      .NUM_SEGMENTS (TABLE_DEPTH)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_size      (req_size),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_start_res (rsp_start_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // table state right after reset: one free segment over the whole disk
   task automatic clear_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_base[i] = '0;
         tbl_len[i]  = '0;
         tbl_used[i] = 1'b0;
      end
      tbl_len[0] = SIZE_W'(DISK_UNITS);
      tbl_live   = 1;
   endtask

   // apply one request to the shadow table and return the reply it earns
   function automatic reply_t serve_request(logic kind, logic [SIZE_W-1:0] len,
                                            logic [ADDR_W-1:0] address);
      reply_t            r;
      int                hit;
      int                i;
      logic [ADDR_W-1:0] old_base;
      r.status    = STATUS_NOT_FOUND;
      r.start_res = '0;
      hit         = -1;
      if (kind == REQ_ALLOC) begin
         r.status = STATUS_NO_SPACE;
         // first free segment strictly longer than the request
         for (i = 0; i < tbl_live && hit < 0; i++)
            if (!tbl_used[i] && tbl_len[i] > len)
               hit = i;
         if (hit >= 0) begin
            // fit test comes first, table-full only when something fits
            if (tbl_live >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               old_base            = tbl_base[hit];
               tbl_base[hit]       = ADDR_W'(old_base + len);
               tbl_len[hit]        = tbl_len[hit] - len;
               tbl_base[tbl_live]  = old_base;
               tbl_len[tbl_live]   = len;
               tbl_used[tbl_live]  = 1'b1;
               tbl_live            = tbl_live + 1;
               r.status            = STATUS_OK;
               r.start_res         = old_base;
            end
         end
      end else begin
         // first live entry with that start, busy or already free
         for (i = 0; i < tbl_live && hit < 0; i++)
            if (tbl_base[i] == address)
               hit = i;
         if (hit >= 0) begin
            tbl_used[hit] = 1'b0;
            r.status      = STATUS_OK;
         end
      end
      return r;
   endfunction

   // random request, mostly aimed at live table contents
   task automatic pick_request(output logic kind, output logic [SIZE_W-1:0] len,
                               output logic [ADDR_W-1:0] address);
      int j;
      int roll;
      j       = $urandom_range(tbl_live - 1);
      roll    = $urandom_range(99);
      kind    = ($urandom_range(99) < 58) ? REQ_ALLOC : REQ_FREE;
      address = ADDR_W'($urandom_range(DISK_UNITS - 1));
      // size spread: tiny, medium, whole range, segment boundary, extremes
      if (roll < 40)
         len = SIZE_W'($urandom_range(1023));
      else if (roll < 58)
         len = SIZE_W'($urandom_range(65535));
      else if (roll < 78)
         len = SIZE_W'($urandom_range(DISK_UNITS));
      else if (roll < 94)
         len = (tbl_len[j] == 0) ? '0 : tbl_len[j] - SIZE_W'($urandom_range(1));
      else
         len = $urandom_range(1) ? SIZE_W'(DISK_UNITS) : '0;
      // free addresses: mostly a live start, else a near miss or noise
      roll = $urandom_range(99);
      if (roll < 70)
         address = tbl_base[j];
      else if (roll < 80)
         address = tbl_base[j] + ADDR_W'(1);
   endtask

   // present one request, wait for acceptance, then record its reply
   task automatic issue(logic kind, logic [SIZE_W-1:0] len, logic [ADDR_W-1:0] address,
                        logic known, reply_t typed);
      reply_t predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      start       <= 1'b1;
      req_type    <= kind;
      req_size    <= len;
      req_address <= address;
      do @(posedge clock); while (busy !== 1'b0);
      // transaction taken at this edge
      predicted = serve_request(kind, len, address);
      replies_due.push_back(known ? typed : predicted);
   endtask

   // response check: every strobe must match the oldest outstanding reply
   always @(posedge clock) begin : check_reply
      reply_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (replies_due.size() == 0) begin
            $error("response with no transaction outstanding: status %0d start_res %0d",
                   rsp_status, rsp_start_res);
            fail_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_start_res !== want.start_res) begin
               $error("rsp_start_res: expected %0d, actual %0d",
                      want.start_res, rsp_start_res);
               fail_count++;
            end
            if (!$isunknown(rsp_status))
               status_seen[rsp_status]++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("no progress after %0d cycles, %0d responses outstanding",
                cycle_count, replies_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_t         row;
      logic              kind;
      logic [SIZE_W-1:0] len;
      logic [ADDR_W-1:0] address;

      clear_table();

      // directed rows: extremes, zero size, shared start, unknown start
      directed_rows.push_back('{REQ_ALLOC, 20'd524288, 19'd0,      1'b1,
                                '{STATUS_NO_SPACE, 19'd0}});  // whole disk, not strictly longer
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'd524287, 1'b1,
                                '{STATUS_NOT_FOUND, 19'd0}}); // top address, no entry there
      directed_rows.push_back('{REQ_FREE,  20'd524288, 19'd1,      1'b1,
                                '{STATUS_NOT_FOUND, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd0,      19'd524287, 1'b1,
                                '{STATUS_OK, 19'd0}});        // zero-length segment
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'd0,      1'b1,
                                '{STATUS_OK, 19'd0}});        // already free entry matches first
      directed_rows.push_back('{REQ_ALLOC, 20'd1024,   19'd0,      1'b1,
                                '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'd0,      1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd523264, 19'd0,      1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd523263, 19'd0,      1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd0,      19'd0,      1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd1,      19'd0,      1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'd1024,   1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd523262, 19'd0,      1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'd1024,   1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'd524286, 1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'd0,      19'd524287, 1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'hfffff,  19'd524287, 1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_ALLOC, 20'h55555,  19'h2aaaa,  1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'h2aaaa,  19'd1024,   1'b0, '{STATUS_OK, 19'd0}});
      directed_rows.push_back('{REQ_FREE,  20'd0,      19'h55555,  1'b0, '{STATUS_OK, 19'd0}});

      // reset held from time zero, then released once
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue(row.kind, row.len, row.address, row.known, row.want);
      end

      // random phases: sender idles rarely, often, then never
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 72 : 0;
         repeat (RANDOM_ITEMS) begin
            pick_request(kind, len, address);
            issue(kind, len, address, 1'b0, '{STATUS_OK, '0});
         end
      end
      start <= 1'b0;

      // drain, then allow for a stray late strobe
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("responses: %0d ok, %0d no space, %0d table full, %0d not found",
               status_seen[STATUS_OK], status_seen[STATUS_NO_SPACE],
               status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND]);
      $display("table ended with %0d of %0d entries live", tbl_live, TABLE_DEPTH);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
